/* hw/rtl/bessel_lowpass_iir4_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef BESSEL_LOWPASS_IIR4_MACROS_SVH
`define BESSEL_LOWPASS_IIR4_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLI4_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLI4_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/bli4_pkg.sv */
// Types, constants and helpers shared by the fourth-order low-pass filter.
`default_nettype none

package bli4_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int COEF_BITS    = 32;
   localparam int ACC_BITS     = 48;
   localparam int ACC_FRAC     = ACC_BITS - 8;
   localparam int FF_SHIFT     = COEF_BITS + SAMPLE_BITS - 1 - ACC_FRAC;
   localparam int FB_SHIFT     = COEF_BITS - 5 + SAMPLE_BITS - 1 - ACC_FRAC;
   localparam int OUT_SHIFT    = ACC_FRAC - (SAMPLE_BITS - 1);
   localparam int NUM_TAPS     = 4;
   localparam int TAP_BITS     = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int MUL_A_BITS   = COEF_BITS + 1;
   localparam int PROD_BITS    = MUL_A_BITS + SAMPLE_BITS;
   localparam int PROD6_BITS   = PROD_BITS + 3;

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN           = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FEEDBACK_ONE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FEEDBACK_TWO   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_FEEDBACK_THREE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_FEEDBACK_FOUR  = 3'd4;

   localparam logic [TAP_BITS-1:0] LAST_TAP = TAP_BITS'(NUM_TAPS - 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [COEF_BITS-1:0]   coef_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam acc_type OUT_MAX = {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam acc_type OUT_MIN = {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                load_x;
      logic                mul_ff;
      logic                form_ff;
      logic                load_out;
      logic                mul_fb;
      logic                sum_fb;
      logic                add_fb;
      logic [TAP_BITS-1:0] tap;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // Add with saturation to the accumulator range.
   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
      if (s[ACC_BITS] != s[ACC_BITS-1]) begin
         sat_add = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_add = acc_type'(s[ACC_BITS-1:0]);
      end
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bli4_channels.sv */
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none

interface bli4_req_if;
   logic                 valid;
   logic                 ready;
   bli4_pkg::sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface bli4_rsp_if;
   logic                 valid;
   logic                 ready;
   bli4_pkg::sample_type sample_out;
   logic                 clipped;
   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface bli4_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bli4_pkg::CSR_IDX_BITS-1:0]   index;
   bli4_pkg::coef_type                  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bessel_lowpass_iir4.sv */
// Top level of the fourth-order Bessel low-pass IIR filter.
//
//   channel   direction   carries
//   req_if    in          sample_in (signed Q1.23)
//   rsp_if    out         sample_out (signed Q1.23, saturated), clipped
//   csr_if    in          index, data (gain, feedback_one .. feedback_four)
//
// A new sample is accepted only when the sequencer has returned to idle: one
// multiplier is shared by the feed-forward product and the four feedback products,
// each feedback tap taking a multiply, a sum and an accumulate step.
// The result enters the output register after the ST_MUL_FF and ST_FORM steps.
// Reset clears the coefficients and the four accumulators.
// A stalled result holds the sequencer before the output register is reloaded.
`default_nettype none

`include "bessel_lowpass_iir4_macros.svh"

module bessel_lowpass_iir4 (
   input wire logic   clock,
   input wire logic   reset,
   bli4_req_if.sink   req_if,
   bli4_rsp_if.source rsp_if,
   bli4_csr_if.sink   csr_if
);

   bli4_pkg::cmd_type    cmd;
   bli4_pkg::status_type status;

   assign csr_if.ready = 1'b1;

   bli4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bli4_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_if.sample_in),
      .csr_we      (csr_if.valid),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_sample  (rsp_if.sample_out),
      .rsp_clipped (rsp_if.clipped)
   );

   `BLI4_ASSERT_NXT(a_one_in_flight, clock, reset,
      req_if.valid && req_if.ready, !req_if.ready,
      "new transaction accepted while a sample is in flight")

   `BLI4_ASSERT_IMP(a_no_overwrite, clock, reset,
      cmd.load_out, !(rsp_if.valid && !rsp_if.ready),
      "output register reloaded while a result is stalled")

   `BLI4_ASSERT_IMP(a_clip_extreme, clock, reset,
      rsp_if.valid && rsp_if.clipped,
      rsp_if.sample_out == bli4_pkg::SAMPLE_MAX || rsp_if.sample_out == bli4_pkg::SAMPLE_MIN,
      "clipped result is not a full-scale value")

endmodule

`default_nettype wire

/* hw/rtl/bli4_ctrl.sv */
// Sequencer that steps one sample through the shared-multiplier datapath.
`default_nettype none

module bli4_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bli4_pkg::status_type status,
   output bli4_pkg::cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_FF = 3'd1;
   localparam logic [2:0] ST_FORM   = 3'd2;
   localparam logic [2:0] ST_OUT    = 3'd3;
   localparam logic [2:0] ST_FB_MUL = 3'd4;
   localparam logic [2:0] ST_FB_SUM = 3'd5;
   localparam logic [2:0] ST_FB_ADD = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic [bli4_pkg::TAP_BITS-1:0] tap_ff, tap_in;

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.tap   = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = ST_MUL_FF;
            end
         end
         ST_MUL_FF: begin
            cmd.mul_ff = 1'b1;
            state_in   = ST_FORM;
         end
         ST_FORM: begin
            cmd.form_ff = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // hold until the previous transaction has left the output register
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               tap_in       = '0;
               state_in     = ST_FB_MUL;
            end
         end
         ST_FB_MUL: begin
            cmd.mul_fb = 1'b1;
            state_in   = ST_FB_SUM;
         end
         ST_FB_SUM: begin
            cmd.sum_fb = 1'b1;
            state_in   = ST_FB_ADD;
         end
         ST_FB_ADD: begin
            cmd.add_fb = 1'b1;
            if (tap_ff == bli4_pkg::LAST_TAP) begin
               state_in = ST_IDLE;
            end else begin
               tap_in   = tap_ff + bli4_pkg::TAP_BITS'(1);
               state_in = ST_FB_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bli4_datapath.sv */
// Coefficient registers, shared multiplier, accumulators and output register.
`default_nettype none

module bli4_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bli4_pkg::cmd_type                   cmd,
   output bli4_pkg::status_type                     status,
   input  wire bli4_pkg::sample_type                req_sample,
   input  wire logic                                csr_we,
   input  wire logic [bli4_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire bli4_pkg::coef_type                  csr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output bli4_pkg::sample_type                     rsp_sample,
   output logic                                     rsp_clipped
);

   bli4_pkg::coef_type   gain_ff;
   bli4_pkg::coef_type   fb_ff [bli4_pkg::NUM_TAPS];
   bli4_pkg::acc_type    acc_ff [bli4_pkg::NUM_TAPS];
   bli4_pkg::sample_type x_ff;
   bli4_pkg::prod_type   prod_ff;
   bli4_pkg::acc_type    ff1_ff, ff4_ff, ff6_ff;
   bli4_pkg::acc_type    sum_ff;
   bli4_pkg::sample_type rsp_sample_ff;
   logic                 rsp_clipped_ff;
   logic                 rsp_valid_ff;

   logic signed [bli4_pkg::MUL_A_BITS-1:0]  mul_a;
   bli4_pkg::sample_type                    mul_b;
   bli4_pkg::prod_type                      prod_in;
   logic signed [bli4_pkg::PROD6_BITS-1:0]  prod_ext, prod6;
   bli4_pkg::acc_type                       y_acc, y_shift, fb_term, ff_sel, acc_in;
   bli4_pkg::sample_type                    y_in;
   logic                                    clip_in;
   logic [bli4_pkg::TAP_BITS-1:0]           tap_next;

   // Shared multiplier: gain times sample, or a feedback ratio times the output
   always_comb begin
      if (cmd.mul_fb) begin
         mul_a = {fb_ff[cmd.tap][bli4_pkg::COEF_BITS-1], fb_ff[cmd.tap]};
         mul_b = rsp_sample_ff;
      end else begin
         mul_a = {1'b0, gain_ff};
         mul_b = x_ff;
      end
      prod_in = mul_a * mul_b;
   end

   // Feed-forward terms: floor(k * gain * x / 2^FF_SHIFT) for k = 1, 4, 6
   always_comb begin
      prod_ext = bli4_pkg::PROD6_BITS'(prod_ff);
      prod6    = (prod_ext <<< 2) + (prod_ext <<< 1);
   end

   // Output sample: narrow the first accumulator sum with saturation
   always_comb begin
      y_acc   = bli4_pkg::sat_add(ff1_ff, acc_ff[0]);
      y_shift = y_acc >>> bli4_pkg::OUT_SHIFT;
      clip_in = 1'b0;
      if (y_shift > bli4_pkg::OUT_MAX) begin
         y_in    = bli4_pkg::SAMPLE_MAX;
         clip_in = 1'b1;
      end else if (y_shift < bli4_pkg::OUT_MIN) begin
         y_in    = bli4_pkg::SAMPLE_MIN;
         clip_in = 1'b1;
      end else begin
         y_in = bli4_pkg::sample_type'(y_shift);
      end
   end

   // Feedback tap update
   always_comb begin
      fb_term  = bli4_pkg::acc_type'(prod_ff >>> bli4_pkg::FB_SHIFT);
      tap_next = cmd.tap + bli4_pkg::TAP_BITS'(1);
      case (cmd.tap)
         2'd0:    ff_sel = ff4_ff;
         2'd1:    ff_sel = ff6_ff;
         2'd2:    ff_sel = ff4_ff;
         default: ff_sel = ff1_ff;
      endcase
      if (cmd.tap == bli4_pkg::LAST_TAP) begin
         acc_in = sum_ff;
      end else begin
         acc_in = bli4_pkg::sat_add(sum_ff, acc_ff[tap_next]);
      end
   end

   // Configuration registers and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         for (int i = 0; i < bli4_pkg::NUM_TAPS; i++) begin
            fb_ff[i]  <= '0;
            acc_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bli4_pkg::REG_GAIN:           gain_ff  <= csr_data;
               bli4_pkg::REG_FEEDBACK_ONE:   fb_ff[0] <= csr_data;
               bli4_pkg::REG_FEEDBACK_TWO:   fb_ff[1] <= csr_data;
               bli4_pkg::REG_FEEDBACK_THREE: fb_ff[2] <= csr_data;
               bli4_pkg::REG_FEEDBACK_FOUR:  fb_ff[3] <= csr_data;
               default: ;
            endcase
         end
         if (cmd.add_fb) begin
            acc_ff[cmd.tap] <= acc_in;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= req_sample;
      end
      if (cmd.mul_ff || cmd.mul_fb) begin
         prod_ff <= prod_in;
      end
      if (cmd.form_ff) begin
         ff1_ff <= bli4_pkg::acc_type'(prod_ff >>> bli4_pkg::FF_SHIFT);
         ff4_ff <= bli4_pkg::acc_type'(prod_ff >>> (bli4_pkg::FF_SHIFT - 2));
         ff6_ff <= bli4_pkg::acc_type'(prod6 >>> bli4_pkg::FF_SHIFT);
      end
      if (cmd.sum_fb) begin
         sum_ff <= bli4_pkg::sat_add(ff_sel, fb_term);
      end
      if (cmd.load_out) begin
         rsp_sample_ff  <= y_in;
         rsp_clipped_ff <= clip_in;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_clipped     = rsp_clipped_ff;

endmodule

`default_nettype wire
